@@ hdl/sgrad_pkg.sv @@
// Shared types and constants for the 3x3 Sobel gradient block.
// Depends on nothing; every other file but sgrad_line_buffer refers to it by scoped names.
`default_nettype none

package sgrad_pkg;

  localparam int CFG_DATA_BITS  = 12;
  localparam int CFG_INDEX_BITS = 2;
  localparam int COORD_BITS     = 11;
  localparam int GRAD_BITS      = 11;
  localparam int ROW_BITS       = 11;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_DATA_BITS-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [CFG_DATA_BITS-1:0] MIN_DIM      = 12'd3;
  localparam logic [CFG_DATA_BITS-1:0] MAX_HEIGHT   = 12'd2048;

  // Position and flags of one window centre, travelling with the pixel.
  typedef struct packed {
    logic                  interior;
    logic                  frame_last;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
  } pos_t;

endpackage

`default_nettype wire

@@ hdl/sobel_gradient_3x3.sv @@
// Top level of the 3x3 Sobel gradient block: counters, configuration,
// pipeline control and result register. Uses sgrad_pkg, sgrad_line_buffer
// and sgrad_window.
//
// Pixels arrive in raster order, one per clock at full rate while the result
// register can take a value, and each interior window centre yields one
// transaction carrying the horizontal and vertical Sobel sums (derivative
// times eight) with its column and row; border centres give nothing. The edge
// that accepts the pixel completing its window captures that pixel and the
// registered read of the line buffer (one MAX_WIDTH-deep memory holding both
// previous rows); then the window register is loaded, and after it the result
// register. The pipeline advances as a whole, so a result held by the
// consumer stalls the input.
// Writing image_width or image_height restarts the frame at row 0, column 0.
`default_nettype none

module sobel_gradient_3x3 #(
  parameter int MAX_WIDTH = 2048,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [sgrad_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [sgrad_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [PIXEL_BITS-1:0]                  pixel,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [sgrad_pkg::GRAD_BITS-1:0]      grad_x,
  output logic signed [sgrad_pkg::GRAD_BITS-1:0]      grad_y,
  output logic [sgrad_pkg::COORD_BITS-1:0]            center_x,
  output logic [sgrad_pkg::COORD_BITS-1:0]            center_y,
  output logic                                        frame_last
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (CW > sgrad_pkg::CFG_DATA_BITS) ? CW : sgrad_pkg::CFG_DATA_BITS;
  localparam int RB   = sgrad_pkg::ROW_BITS;
  localparam int DB   = sgrad_pkg::CFG_DATA_BITS;

  logic [DB-1:0]         image_width;
  logic [DB-1:0]         image_height;
  logic [AW-1:0]         col;
  logic [AW-1:0]         col_next;
  logic [RB-1:0]         row;
  logic [RB-1:0]         row_next;
  logic [CMPW-1:0]       width_wide;
  logic [CW-1:0]         w_eff;
  logic [CW-1:0]         w_last;
  logic [DB-1:0]         h_eff;
  logic [DB-1:0]         h_last;
  logic                  col_wrap;
  logic                  row_wrap;
  logic                  en;
  logic                  accept;
  logic                  cfg_hit;

  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_px;
  logic [AW-1:0]         s1_col;
  sgrad_pkg::pos_t       s1_pos;
  sgrad_pkg::pos_t       pos_next;

  logic [2*PIXEL_BITS-1:0] rd_data;
  logic                    s2_valid;
  sgrad_pkg::pos_t         s2_pos;
  logic signed [sgrad_pkg::GRAD_BITS-1:0] win_gx;
  logic signed [sgrad_pkg::GRAD_BITS-1:0] win_gy;

  // The whole pipeline moves whenever the result register can take a value.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     (cfg_index == sgrad_pkg::REG_IMAGE_WIDTH ||
                      cfg_index == sgrad_pkg::REG_IMAGE_HEIGHT);

  always_comb begin
    width_wide = CMPW'(image_width);
    if (width_wide < CMPW'(sgrad_pkg::MIN_DIM)) begin
      w_eff = CW'(sgrad_pkg::MIN_DIM);
    end else if (width_wide > CMPW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_wide);
    end
    w_last = w_eff - CW'(1);

    if (image_height < sgrad_pkg::MIN_DIM) begin
      h_eff = sgrad_pkg::MIN_DIM;
    end else if (image_height > sgrad_pkg::MAX_HEIGHT) begin
      h_eff = sgrad_pkg::MAX_HEIGHT;
    end else begin
      h_eff = image_height;
    end
    h_last = h_eff - DB'(1);

    col_wrap = (CW'(col) == w_last);
    row_wrap = (DB'(row) == h_last);
    col_next = col_wrap ? '0 : col + AW'(1);
    if (col_wrap) begin
      row_next = row_wrap ? '0 : row + RB'(1);
    end else begin
      row_next = row;
    end

    pos_next.interior   = (row >= RB'(2)) && (col >= AW'(2));
    pos_next.frame_last = col_wrap && row_wrap;
    pos_next.center_x   = sgrad_pkg::COORD_BITS'(col - AW'(1));
    pos_next.center_y   = sgrad_pkg::COORD_BITS'(row - RB'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sgrad_pkg::WIDTH_RESET;
      image_height <= sgrad_pkg::HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == sgrad_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px  <= pixel;
      s1_col <= col;
      s1_pos <= pos_next;
    end
  end

  // Each entry holds {row two above, row just above} for its column.
  sgrad_line_buffer #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (2 * PIXEL_BITS)
  ) u_line_buffer (
    .clk     (clk),
    .rd_en   (en),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (en && s1_valid),
    .wr_addr (s1_col),
    .wr_data ({rd_data[PIXEL_BITS-1:0], s1_px})
  );

  sgrad_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .load     (s1_valid),
    .row_top  (rd_data[2*PIXEL_BITS-1:PIXEL_BITS]),
    .row_mid  (rd_data[PIXEL_BITS-1:0]),
    .px       (s1_px),
    .pos_in   (s1_pos),
    .s2_valid (s2_valid),
    .pos_out  (s2_pos),
    .grad_x   (win_gx),
    .grad_y   (win_gy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid && s2_pos.interior;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grad_x     <= win_gx;
      grad_y     <= win_gy;
      center_x   <= s2_pos.center_x;
      center_y   <= s2_pos.center_y;
      frame_last <= s2_pos.frame_last;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sgrad_line_buffer.sv @@
// Line buffer for the Sobel block: one entry per column holding the two
// previous rows side by side. Registered read port, one write port.
`default_nettype none

module sgrad_line_buffer #(
  parameter int DEPTH = 2048,
  parameter int DATA_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_BITS-1:0]     rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0]     wr_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/sgrad_window.sv @@
// 3x3 pixel window and the Sobel kernel sums with saturation to 11 bits.
// Depends on sgrad_pkg for the position struct and field widths.
`default_nettype none

module sgrad_window #(
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                load,
  input  wire logic [PIXEL_BITS-1:0]               row_top,
  input  wire logic [PIXEL_BITS-1:0]               row_mid,
  input  wire logic [PIXEL_BITS-1:0]               px,
  input  wire sgrad_pkg::pos_t                     pos_in,
  output logic                                     s2_valid,
  output sgrad_pkg::pos_t                          pos_out,
  output logic signed [sgrad_pkg::GRAD_BITS-1:0]   grad_x,
  output logic signed [sgrad_pkg::GRAD_BITS-1:0]   grad_y
);

  localparam int SW = PIXEL_BITS + 3;
  localparam int WW = (SW > sgrad_pkg::GRAD_BITS) ? SW : sgrad_pkg::GRAD_BITS;
  localparam logic signed [WW-1:0] SAT_HI = WW'(1023);
  localparam logic signed [WW-1:0] SAT_LO = WW'(-1024);

  // Layout is row*3+col with column 2 the newest pixel.
  logic [PIXEL_BITS-1:0] win [9];
  logic signed [SW-1:0]  e [9];
  logic signed [SW-1:0]  gx_sum;
  logic signed [SW-1:0]  gy_sum;
  logic signed [WW-1:0]  gx_wide;
  logic signed [WW-1:0]  gy_wide;

  always_ff @(posedge clk) begin
    if (en && load) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]     <= win[r*3 + 1];
        win[r*3 + 1] <= win[r*3 + 2];
      end
      win[2] <= row_top;
      win[5] <= row_mid;
      win[8] <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_out <= pos_in;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = signed'(SW'(win[i]));
    end
    gx_sum = (e[2] - e[0]) + ((e[5] - e[3]) <<< 1) + (e[8] - e[6]);
    gy_sum = (e[6] - e[0]) + ((e[7] - e[1]) <<< 1) + (e[8] - e[2]);
    gx_wide = WW'(gx_sum);
    gy_wide = WW'(gy_sum);
    if (gx_wide > SAT_HI) begin
      grad_x = sgrad_pkg::GRAD_BITS'(SAT_HI);
    end else if (gx_wide < SAT_LO) begin
      grad_x = sgrad_pkg::GRAD_BITS'(SAT_LO);
    end else begin
      grad_x = sgrad_pkg::GRAD_BITS'(gx_wide);
    end
    if (gy_wide > SAT_HI) begin
      grad_y = sgrad_pkg::GRAD_BITS'(SAT_HI);
    end else if (gy_wide < SAT_LO) begin
      grad_y = sgrad_pkg::GRAD_BITS'(SAT_LO);
    end else begin
      grad_y = sgrad_pkg::GRAD_BITS'(gy_wide);
    end
  end

endmodule

`default_nettype wire

@@ hdl/sgrad_checker.sv @@
// Port-level checks for sobel_gradient_3x3 and the bind that attaches them.
// Depends on sgrad_pkg for field widths.
`default_nettype none

module sgrad_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_ready,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire logic signed [sgrad_pkg::GRAD_BITS-1:0] grad_x,
  input wire logic signed [sgrad_pkg::GRAD_BITS-1:0] grad_y,
  input wire logic [sgrad_pkg::COORD_BITS-1:0]      center_x,
  input wire logic [sgrad_pkg::COORD_BITS-1:0]      center_y,
  input wire logic                                  frame_last
);

  // After reset no result is offered.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // A result that is not taken keeps its transaction unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(grad_x) && $stable(grad_y) &&
      $stable(center_x) && $stable(center_y) && $stable(frame_last))
    else $error("stalled result changed");

  // Only interior centres produce results.
  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> center_x != '0 && center_y != '0)
    else $error("result for a border centre");

  // A stalled result stalls the pixel input as well.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

endmodule

bind sobel_gradient_3x3 sgrad_checker u_sgrad_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .grad_x     (grad_x),
  .grad_y     (grad_y),
  .center_x   (center_x),
  .center_y   (center_y),
  .frame_last (frame_last)
);

`default_nettype wire
